@@ hdl/nosc_pkg.sv @@
package nosc_pkg;

  // Coordinate width default for the top level parameter
  localparam int COORD_BITS_DEF = 24;

  // Fixed field widths
  localparam int RADIUS_W   = 23;
  localparam int ID_W       = 16;
  localparam int ROOT_W     = 25;
  localparam int CLR_W      = 27;
  localparam int OUT_DIST_W = 26;
  localparam int CFG_DIST_W = 25;
  localparam int CFG_IDX_W  = 2;

  // Sum of squares at or above 2^SQ_LIMIT_LOG saturates the distance
  localparam int SQ_LIMIT_LOG = 50;
  localparam int REM_W        = ROOT_W + 3;
  localparam int ROOT_STEPS   = ROOT_W;
  localparam int STEP_W       = 5;

  // Intermediate queue depth between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WARNING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESTOP_EN = 2'd2;

  // Reset values
  localparam logic [CFG_DIST_W-1:0] WARNING_RESET  = 25'd512;
  localparam logic [CFG_DIST_W-1:0] CRITICAL_RESET = 25'd128;
  localparam logic                  ESTOP_RESET    = 1'b1;
  localparam logic signed [CLR_W-1:0] BEST_RESET   = 27'sd67108863;
  localparam logic [ROOT_W-1:0]     DIST_SAT       = 25'h1FFFFFF;

  // One classified point travelling from front to back
  typedef struct packed {
    logic signed [CLR_W-1:0] clr;
    logic [ID_W-1:0]         id;
    logic                    last;
  } nosc_qent_t;

  // Configuration register set
  typedef struct packed {
    logic [CFG_DIST_W-1:0] warning_distance;
    logic [CFG_DIST_W-1:0] critical_distance;
    logic                  emergency_stop_enable;
  } nosc_cfg_t;

endpackage

@@ hdl/nosc_in_if.sv @@
interface nosc_in_if import nosc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vehicle_x;
  logic signed [COORD_BITS-1:0] vehicle_y;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [RADIUS_W-1:0]          radius;
  logic [ID_W-1:0]              obstacle_id;
  logic                         last;

  modport source (
    output valid, vehicle_x, vehicle_y, point_x, point_y, radius, obstacle_id, last,
    input  ready
  );
  modport sink (
    input  valid, vehicle_x, vehicle_y, point_x, point_y, radius, obstacle_id, last,
    output ready
  );
endinterface

@@ hdl/nosc_out_if.sv @@
interface nosc_out_if import nosc_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic                         safe;
  logic                         emergency_stop;
  logic                         warning;
  logic [ID_W-1:0]              nearest_id;
  logic signed [OUT_DIST_W-1:0] min_distance;

  modport source (
    output valid, safe, emergency_stop, warning, nearest_id, min_distance,
    input  ready
  );
  modport sink (
    input  valid, safe, emergency_stop, warning, nearest_id, min_distance,
    output ready
  );
endinterface

@@ hdl/nosc_cfg_if.sv @@
interface nosc_cfg_if import nosc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DIST_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ hdl/nosc_front.sv @@
module nosc_front import nosc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  nosc_in_if.sink            in_ch,
  output logic               push_valid,
  input  logic               push_ready,
  output nosc_qent_t         push_data
);

  localparam int DW  = COORD_BITS + 1;
  localparam int SQW = (2 * DW > SQ_LIMIT_LOG + 1) ? 2 * DW : SQ_LIMIT_LOG + 1;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_SUM  = 3'd2;
  localparam logic [2:0] F_ROOT = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]                state_r, state_nxt;
  logic [DW-1:0]             ax_r, ay_r;
  logic [2*DW-1:0]           sx_r, sy_r;
  logic [SQ_LIMIT_LOG-1:0]   rad_r;
  logic [REM_W-1:0]          rem_r;
  logic [ROOT_W-1:0]         root_r;
  logic [STEP_W-1:0]         cnt_r;
  logic                      sat_r;
  logic [RADIUS_W-1:0]       radius_r;
  logic [ID_W-1:0]           id_r;
  logic                      last_r;

  logic signed [DW-1:0]      dx, dy;
  logic [DW-1:0]             ax, ay;
  logic [SQW-1:0]            sum_w;
  logic [REM_W-1:0]          rem_sh, trial;
  logic                      take;
  logic [ROOT_W-1:0]         reach;

  // Exact differences and their magnitudes
  always_comb begin
    dx = {in_ch.vehicle_x[COORD_BITS-1], in_ch.vehicle_x}
       - {in_ch.point_x[COORD_BITS-1], in_ch.point_x};
    dy = {in_ch.vehicle_y[COORD_BITS-1], in_ch.vehicle_y}
       - {in_ch.point_y[COORD_BITS-1], in_ch.point_y};
    ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
  end

  // Sum of squares, wide enough to never wrap
  assign sum_w = SQW'(sx_r) + SQW'(sy_r);

  // One root bit per step: bring down two radicand bits and try a one
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[SQ_LIMIT_LOG-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign take   = (rem_sh >= trial);

  // Clearance: saturated or rooted distance minus radius
  assign reach = sat_r ? DIST_SAT : root_r;
  assign push_data.clr  = $signed({2'b00, reach}) - $signed({4'b0000, radius_r});
  assign push_data.id   = id_r;
  assign push_data.last = last_r;

  assign in_ch.ready = (state_r == F_IDLE);
  assign push_valid  = (state_r == F_PUSH);

  // Sequence one item through the arithmetic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_ch.valid) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_SUM;
      F_SUM:  state_nxt = F_ROOT;
      F_ROOT: if (cnt_r == STEP_W'(ROOT_STEPS - 1)) state_nxt = F_PUSH;
      F_PUSH: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          ax_r     <= ax;
          ay_r     <= ay;
          radius_r <= in_ch.radius;
          id_r     <= in_ch.obstacle_id;
          last_r   <= in_ch.last;
        end
      end
      F_MUL: begin
        sx_r <= ax_r * ax_r;
        sy_r <= ay_r * ay_r;
      end
      F_SUM: begin
        sat_r  <= |sum_w[SQW-1:SQ_LIMIT_LOG];
        rad_r  <= sum_w[SQ_LIMIT_LOG-1:0];
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      F_ROOT: begin
        rad_r  <= {rad_r[SQ_LIMIT_LOG-3:0], 2'b00};
        rem_r  <= take ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[ROOT_W-2:0], take};
        cnt_r  <= cnt_r + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/nosc_fifo.sv @@
module nosc_fifo import nosc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  nosc_qent_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output nosc_qent_t pop_data
);

  nosc_qent_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 do_push, do_pop;

  assign push_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store incoming items
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/nosc_back.sv @@
module nosc_back import nosc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  nosc_cfg_t  cfg,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  nosc_qent_t pop_data,
  nosc_out_if.source out_ch
);

  logic signed [CLR_W-1:0] best_r;
  logic [ID_W-1:0]         best_id_r;
  logic                    out_valid_r;
  logic                    safe_r, estop_r, warn_r;
  logic [ID_W-1:0]         id_out_r;
  logic [OUT_DIST_W-1:0]   dist_out_r;

  logic                    pop;
  logic                    better;
  logic signed [CLR_W-1:0] best_nxt;
  logic [ID_W-1:0]         id_nxt;
  logic                    unsafe;

  // A last item needs a free output slot; other items drain at once
  assign pop_ready = !pop_data.last || !out_valid_r || out_ch.ready;
  assign pop       = pop_valid && pop_ready;

  // Strict minimum so the earliest point keeps a tie
  always_comb begin
    better   = (pop_data.clr < best_r);
    best_nxt = better ? pop_data.clr : best_r;
    id_nxt   = better ? pop_data.id : best_id_r;
    unsafe   = (best_nxt < $signed({2'b00, cfg.critical_distance}));
  end

  // Running minimum, restarted after each scene
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r    <= BEST_RESET;
      best_id_r <= '0;
    end else if (pop) begin
      if (pop_data.last) begin
        best_r    <= BEST_RESET;
        best_id_r <= '0;
      end else begin
        best_r    <= best_nxt;
        best_id_r <= id_nxt;
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && pop_data.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_data.last) begin
      safe_r     <= !unsafe;
      estop_r    <= unsafe && cfg.emergency_stop_enable;
      warn_r     <= (best_nxt < $signed({2'b00, cfg.warning_distance}));
      id_out_r   <= id_nxt;
      dist_out_r <= best_nxt[OUT_DIST_W-1:0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.safe           = safe_r;
  assign out_ch.emergency_stop = estop_r;
  assign out_ch.warning        = warn_r;
  assign out_ch.nearest_id     = id_out_r;
  assign out_ch.min_distance   = $signed(dist_out_r);

endmodule

@@ hdl/nearest_obstacle_safety_check_core.sv @@
// Nearest obstacle safety check.
// in_ch carries one obstacle point per item: vehicle position, point, radius,
// obstacle id and a last flag that closes a scene. For each point the core
// forms the Euclidean distance minus the radius and keeps the smallest value
// with its id. On the last item of a scene one result leaves on out_ch with
// the safe, warning and emergency stop flags, the nearest id and the distance.
// cfg_ch writes the warning distance, critical distance and stop enable; it is
// always ready and should only be used while the core is idle.
// The front takes an item only while idle: it squares the differences, sums
// them and then runs a bit-serial square root of 25 steps before handing the
// clearance to the back through a two-entry queue; then it takes the next.
// The back registers the result when the last item of a scene leaves the queue.
// Reset clears the queue, the running minimum and the output register and
// loads the threshold defaults. When the receiver stalls the result holds in
// the output register; the front keeps accepting points until the queue fills.
module nearest_obstacle_safety_check_core import nosc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  nosc_in_if.sink     in_ch,
  nosc_out_if.source  out_ch,
  nosc_cfg_if.sink    cfg_ch
);

  nosc_cfg_t  cfg_r;
  logic       push_valid, push_ready;
  nosc_qent_t push_data;
  logic       pop_valid, pop_ready;
  nosc_qent_t pop_data;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warning_distance      <= WARNING_RESET;
      cfg_r.critical_distance     <= CRITICAL_RESET;
      cfg_r.emergency_stop_enable <= ESTOP_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_WARNING:  cfg_r.warning_distance      <= cfg_ch.data;
        REG_CRITICAL: cfg_r.critical_distance     <= cfg_ch.data;
        REG_ESTOP_EN: cfg_r.emergency_stop_enable <= cfg_ch.data[0];
        default: begin
        end
      endcase
    end
  end

  nosc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  nosc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  nosc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule
